@@ src/aesm_pkg.sv @@
// Shared types, constants and the code decode table of the encoder speed monitor.
package aesm_pkg;

  // Field widths.
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned DELTA_W = 8;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned WIN_W   = 7;
  localparam int unsigned THR_W   = 13;

  // Configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0]  REG_WINDOW = 2'd0;
  localparam logic [1:0]  REG_LOW    = 2'd1;
  localparam logic [1:0]  REG_HIGH   = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RESET   = 7'd26;
  localparam logic [THR_W-1:0] LOW_THR_RESET  = 13'd16;
  localparam logic [THR_W-1:0] HIGH_THR_RESET = 13'd32;

  // Longest window that may be summed.
  localparam int unsigned WINDOW_MAX = 64;

  // Wrap detection limits for the position change.
  localparam logic [POS_W-1:0] WRAP_LOW  = 7'd28;
  localparam logic [POS_W-1:0] WRAP_HIGH = 7'd100;
  localparam logic signed [8:0] POS_SPAN = 9'sd128;

  // Depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SET   = 2'd1,
    EV_CLEAR = 2'd2
  } ev_e;

  // One classified sample on its way from the front to the back end.
  typedef struct packed {
    logic                      enc;
    logic [POS_W-1:0]          pos;
    logic                      err;
    logic signed [DELTA_W-1:0] delta;
  } ent_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [THR_W-1:0] low_thr;
    logic [THR_W-1:0] high_thr;
    logic             clear;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } dec_t;

  // Pin code of each of the 128 positions.
  localparam logic [CODE_W-1:0] CODE_TABLE [128] = '{
    8'd127, 8'd63,  8'd62,  8'd58,  8'd56,  8'd184, 8'd152, 8'd24,  8'd8,   8'd72,
    8'd73,  8'd77,  8'd79,  8'd15,  8'd47,  8'd175, 8'd191, 8'd159, 8'd31,  8'd29,
    8'd28,  8'd92,  8'd76,  8'd12,  8'd4,   8'd36,  8'd164, 8'd166, 8'd167, 8'd135,
    8'd151, 8'd215, 8'd223, 8'd207, 8'd143, 8'd142, 8'd14,  8'd46,  8'd38,
    8'd6,   8'd2,   8'd18,  8'd82,  8'd83,  8'd211, 8'd195, 8'd203, 8'd235, 8'd239,
    8'd231, 8'd199, 8'd71,  8'd7,   8'd23,  8'd19,  8'd3,   8'd1,   8'd9,   8'd41,  8'd169,
    8'd233, 8'd225, 8'd229, 8'd245, 8'd247, 8'd243, 8'd227, 8'd163,
    8'd131, 8'd139, 8'd137, 8'd129, 8'd128, 8'd132,
    8'd148, 8'd212, 8'd244, 8'd240, 8'd242, 8'd250, 8'd251, 8'd249, 8'd241, 8'd209,
    8'd193, 8'd197, 8'd196, 8'd192, 8'd64,  8'd66,  8'd74,  8'd106, 8'd122, 8'd120, 8'd121,
    8'd125, 8'd253, 8'd252, 8'd248, 8'd232, 8'd224, 8'd226, 8'd98,  8'd96,  8'd32,  8'd33,
    8'd37,  8'd53,  8'd61,  8'd60,  8'd188, 8'd190, 8'd254, 8'd126, 8'd124, 8'd116, 8'd112,
    8'd113, 8'd49,  8'd48,  8'd16,  8'd144, 8'd146, 8'd154, 8'd158, 8'd30,  8'd94,  8'd95
  };

  // Inverse lookup; the lowest matching position wins.
  function automatic dec_t decode_code(input logic [CODE_W-1:0] code);
    dec_t r;
    r.found = 1'b0;
    r.pos   = '0;
    for (int i = 127; i >= 0; i--) begin
      if (CODE_TABLE[i] == code) begin
        r.found = 1'b1;
        r.pos   = POS_W'(i);
      end
    end
    return r;
  endfunction

  function automatic ev_e event_of(input logic before_flag, input logic now_flag);
    ev_e r;
    r = EV_NONE;
    if (!before_flag && now_flag) begin
      r = EV_SET;
    end else if (before_flag && !now_flag) begin
      r = EV_CLEAR;
    end
    return r;
  endfunction

endpackage

@@ src/aesm_front.sv @@
// Front end: accepts samples, decodes the pin code and forms the wrap-aware position change.
module aesm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         encoder_select_i,
  input  logic [aesm_pkg::CODE_W-1:0]  raw_code_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output aesm_pkg::ent_t               q_item_o
);
  import aesm_pkg::*;

  logic [POS_W-1:0]  last_pos_q [2];
  logic [POS_W-1:0]  last_pos_d [2];
  logic              accept;
  dec_t              dec;
  logic [POS_W-1:0]  prev_pos;
  logic [POS_W-1:0]  new_pos;
  logic signed [8:0] diff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    dec      = decode_code(raw_code_i);
    prev_pos = last_pos_q[encoder_select_i];
    new_pos  = dec.found ? dec.pos : prev_pos;
    diff     = $signed({2'b00, new_pos}) - $signed({2'b00, prev_pos});
    if (new_pos < WRAP_LOW && prev_pos > WRAP_HIGH) begin
      diff = diff + POS_SPAN;
    end else if (new_pos > WRAP_HIGH && prev_pos < WRAP_LOW) begin
      diff = diff - POS_SPAN;
    end
    q_item_o.enc   = encoder_select_i;
    q_item_o.pos   = new_pos;
    q_item_o.err   = !dec.found;
    q_item_o.delta = diff[DELTA_W-1:0];
  end

  always_comb begin
    last_pos_d = last_pos_q;
    if (accept) begin
      last_pos_d[encoder_select_i] = new_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q[0] <= '0;
      last_pos_q[1] <= '0;
    end else begin
      last_pos_q <= last_pos_d;
    end
  end

endmodule

@@ src/aesm_queue.sv @@
// Short queue of classified samples between the front and the back end.
module aesm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aesm_pkg::ent_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output aesm_pkg::ent_t item_o
);
  import aesm_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  ent_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/aesm_back.sv @@
// Back end: delta rings, running window sums, threshold warnings and the result register.
module aesm_back #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  aesm_pkg::cfg_t                       cfg_i,
  input  logic                                 q_valid_i,
  input  aesm_pkg::ent_t                       q_item_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 encoder_id_o,
  output logic [aesm_pkg::POS_W-1:0]           position_o,
  output logic                                 code_error_o,
  output logic signed [aesm_pkg::DELTA_W-1:0]  step_delta_o,
  output logic signed [aesm_pkg::SUM_W-1:0]    window_sum_o,
  output logic                                 warn_low_o,
  output logic                                 warn_high_o,
  output logic [1:0]                           low_event_o,
  output logic [1:0]                           high_event_o
);
  import aesm_pkg::*;

  localparam int unsigned IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CMP_W     = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 1;
  localparam int unsigned ADDR_BITS = IDX_W + 1;
  localparam int unsigned MEM_DEPTH = 2 * (2 ** IDX_W);
  localparam int unsigned WIN_CAP   = (HISTORY_DEPTH < WINDOW_MAX) ? HISTORY_DEPTH : WINDOW_MAX;
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_X   = CMP_W'(HISTORY_DEPTH);
  localparam logic [WIN_W-1:0]  WIN_CAP_V = WIN_W'(WIN_CAP);

  // Ring memory of both encoders, encoder number in the top address bit.
  logic signed [DELTA_W-1:0] ring_mem [MEM_DEPTH];

  // Per-encoder state.
  logic [IDX_W-1:0]        idx_q  [2];
  logic [IDX_W-1:0]        idx_d  [2];
  logic [FILL_W-1:0]       fill_q [2];
  logic [FILL_W-1:0]       fill_d [2];
  logic signed [SUM_W-1:0] sum_q  [2];
  logic signed [SUM_W-1:0] sum_d  [2];
  logic                    lw_q   [2];
  logic                    lw_d   [2];
  logic                    hw_q   [2];
  logic                    hw_d   [2];

  // Read stage.
  logic                 a_fire;
  logic                 a_enc;
  logic [IDX_W-1:0]     a_idx;
  logic [WIN_W-1:0]     win_eff;
  logic [CMP_W-1:0]     idx_x;
  logic [CMP_W-1:0]     win_x;
  logic [CMP_W-1:0]     old_x;
  logic [IDX_W-1:0]     a_old_idx;
  logic                 a_old_valid;
  logic [ADDR_BITS-1:0] rd_addr;

  // Update stage.
  logic                      b_valid_q, b_valid_d;
  ent_t                      b_item_q;
  logic [IDX_W-1:0]          b_idx_q;
  logic                      b_old_valid_q;
  logic signed [DELTA_W-1:0] rd_q;
  logic                      b_fire;
  logic                      b_enc;
  logic signed [DELTA_W-1:0] b_delta;
  logic signed [DELTA_W-1:0] b_old;
  logic signed [SUM_W-1:0]   b_sum;
  logic [SUM_W-1:0]          b_mag;
  logic                      b_wl;
  logic                      b_wh;
  ev_e                       b_low_ev;
  ev_e                       b_high_ev;
  logic [ADDR_BITS-1:0]      wr_addr;

  logic out_valid_q, out_valid_d;

  always_comb begin
    if (cfg_i.window == '0) begin
      win_eff = WIN_W'(1);
    end else if (cfg_i.window > WIN_CAP_V) begin
      win_eff = WIN_CAP_V;
    end else begin
      win_eff = cfg_i.window;
    end
  end

  // The update stage holds one sample at a time, so a new read never overlaps a pending write.
  assign a_fire  = q_valid_i && !b_valid_q && !cfg_i.clear;
  assign q_pop_o = a_fire;

  always_comb begin
    a_enc       = q_item_i.enc;
    a_idx       = idx_q[a_enc];
    idx_x       = CMP_W'(a_idx);
    win_x       = CMP_W'(win_eff);
    old_x       = (idx_x >= win_x) ? (idx_x - win_x) : (idx_x + DEPTH_X - win_x);
    a_old_idx   = old_x[IDX_W-1:0];
    a_old_valid = (CMP_W'(a_old_idx) < CMP_W'(fill_q[a_enc]));
    rd_addr     = {a_enc, a_old_idx};
  end

  always_comb begin
    idx_d  = idx_q;
    fill_d = fill_q;
    if (cfg_i.clear) begin
      for (int e = 0; e < 2; e++) begin
        idx_d[e]  = '0;
        fill_d[e] = '0;
      end
    end else if (a_fire) begin
      idx_d[a_enc] = (a_idx == IDX_LAST) ? '0 : a_idx + 1'b1;
      if (fill_q[a_enc] != FILL_FULL) begin
        fill_d[a_enc] = fill_q[a_enc] + 1'b1;
      end
    end
  end

  assign b_fire = b_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    b_enc     = b_item_q.enc;
    b_delta   = b_item_q.delta;
    b_old     = b_old_valid_q ? rd_q : '0;
    b_sum     = sum_q[b_enc] + SUM_W'(b_delta) - SUM_W'(b_old);
    b_mag     = b_sum[SUM_W-1] ? unsigned'(-b_sum) : unsigned'(b_sum);
    b_wl      = (b_mag > SUM_W'(cfg_i.low_thr));
    b_wh      = (b_mag > SUM_W'(cfg_i.high_thr));
    b_low_ev  = event_of(lw_q[b_enc], b_wl);
    b_high_ev = event_of(hw_q[b_enc], b_wh);
    wr_addr   = {b_enc, b_idx_q};
  end

  always_comb begin
    sum_d = sum_q;
    lw_d  = lw_q;
    hw_d  = hw_q;
    if (cfg_i.clear) begin
      sum_d[0] = '0;
      sum_d[1] = '0;
    end else if (b_fire) begin
      sum_d[b_enc] = b_sum;
      lw_d[b_enc]  = b_wl;
      hw_d[b_enc]  = b_wh;
    end
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (a_fire) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = b_fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 2; e++) begin
        idx_q[e]  <= '0;
        fill_q[e] <= '0;
        sum_q[e]  <= '0;
        lw_q[e]   <= 1'b0;
        hw_q[e]   <= 1'b0;
      end
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      lw_q        <= lw_d;
      hw_q        <= hw_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      rd_q          <= ring_mem[rd_addr];
      b_item_q      <= q_item_i;
      b_idx_q       <= a_idx;
      b_old_valid_q <= a_old_valid;
    end
    if (b_fire) begin
      ring_mem[wr_addr] <= b_delta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      encoder_id_o <= b_enc;
      position_o   <= b_item_q.pos;
      code_error_o <= b_item_q.err;
      step_delta_o <= b_delta;
      window_sum_o <= b_sum;
      warn_low_o   <= b_wl;
      warn_high_o  <= b_wh;
      low_event_o  <= b_low_ev;
      high_event_o <= b_high_ev;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/absolute_encoder_speed_monitor_top.sv @@
// Top level of the two-encoder speed monitor: configuration registers and block wiring.
//
// Each input transaction carries one sampled pin code of one of two 128-position absolute
// encoders. The code is decoded to a position (an unknown code flags code_error and keeps
// the previous position), the wrap-aware change from that encoder's previous position is
// pushed into the encoder's own ring of HISTORY_DEPTH deltas, and a running sum over the
// newest window_length deltas is compared in magnitude with a low and a high threshold.
// Every input transaction yields exactly one output transaction, in order. The front end
// decodes and forms the change in the cycle of acceptance and hands the sample to a
// two-entry queue; the back end then handles each sample in two steps: it first reads the
// delta that leaves the window from the single-port ring memory, then forms the new sum and
// writes the new delta, and it takes no new sample until the current one is written. A
// sample passes through the queue, the update stage and the output register. While a result
// waits in the output register, the back end can still take the next sample from the queue
// and read its leaving delta, and the queue lets new samples be accepted meanwhile. Ring
// contents are tracked by a fill count per encoder, so no clearing pass is needed after
// reset. Registers sit at byte addresses 0 (window_length, reset 26), 4 (low_threshold,
// reset 16) and 8 (high_threshold, reset 32). Writing window_length empties both rings and
// zeroes both running sums, keeping positions and warning states; it should only be written
// while the block is idle.
module absolute_encoder_speed_monitor_top #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 encoder_select_i,
  input  logic [aesm_pkg::CODE_W-1:0]          raw_code_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 encoder_id_o,
  output logic [aesm_pkg::POS_W-1:0]           position_o,
  output logic                                 code_error_o,
  output logic signed [aesm_pkg::DELTA_W-1:0]  step_delta_o,
  output logic signed [aesm_pkg::SUM_W-1:0]    window_sum_o,
  output logic                                 warn_low_o,
  output logic                                 warn_high_o,
  output logic [1:0]                           low_event_o,
  output logic [1:0]                           high_event_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [aesm_pkg::ADDR_W-1:0]          paddr,
  input  logic [aesm_pkg::DATA_W-1:0]          pwdata,
  output logic [aesm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import aesm_pkg::*;

  logic [WIN_W-1:0] window_q;
  logic [THR_W-1:0] low_thr_q;
  logic [THR_W-1:0] high_thr_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  cfg_t             cfg;

  logic q_full;
  logic q_push;
  ent_t q_in_item;
  logic q_valid;
  logic q_pop;
  ent_t q_out_item;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_RESET;
      low_thr_q  <= LOW_THR_RESET;
      high_thr_q <= HIGH_THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WINDOW: window_q   <= pwdata[WIN_W-1:0];
        REG_LOW:    low_thr_q  <= pwdata[THR_W-1:0];
        REG_HIGH:   high_thr_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW: prdata = DATA_W'(window_q);
      REG_LOW:    prdata = DATA_W'(low_thr_q);
      REG_HIGH:   prdata = DATA_W'(high_thr_q);
      default:    prdata = '0;
    endcase
  end

  // A window write empties the rings at the same clock edge as the register update.
  always_comb begin
    cfg.window   = window_q;
    cfg.low_thr  = low_thr_q;
    cfg.high_thr = high_thr_q;
    cfg.clear    = cfg_wr && (reg_idx == REG_WINDOW);
  end

  aesm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .encoder_select_i (encoder_select_i),
    .raw_code_i       (raw_code_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_item_o         (q_in_item)
  );

  aesm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  aesm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .encoder_id_o (encoder_id_o),
    .position_o   (position_o),
    .code_error_o (code_error_o),
    .step_delta_o (step_delta_o),
    .window_sum_o (window_sum_o),
    .warn_low_o   (warn_low_o),
    .warn_high_o  (warn_high_o),
    .low_event_o  (low_event_o),
    .high_event_o (high_event_o)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of the two-encoder speed monitor.
module tb_top;
  import aesm_pkg::*;

  // The ring depth of the instance; the predictor's ring indices are sized to it.
  localparam int HIST     = 64;
  localparam int SPAN_CAP = 64;
  localparam int IDX_W    = $clog2(HIST);

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Random part: fixed settings first, then a few drawn at random.
  localparam int FIXED_SETTINGS  = 7;
  localparam int RANDOM_SETTINGS = 2;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int OPENING_ROWS    = 22;
  localparam int REPORT_CAP      = 100;

  // Pin code of every position, used both to decode and to shape realistic motion.
  localparam logic [CODE_W-1:0] PIN_CODES [128] = '{
    8'd127, 8'd63,  8'd62,  8'd58,  8'd56,  8'd184, 8'd152, 8'd24,  8'd8,   8'd72,
    8'd73,  8'd77,  8'd79,  8'd15,  8'd47,  8'd175, 8'd191, 8'd159, 8'd31,  8'd29,
    8'd28,  8'd92,  8'd76,  8'd12,  8'd4,   8'd36,  8'd164, 8'd166, 8'd167, 8'd135,
    8'd151, 8'd215, 8'd223, 8'd207, 8'd143, 8'd142, 8'd14,  8'd46,  8'd38,
    8'd6,   8'd2,   8'd18,  8'd82,  8'd83,  8'd211, 8'd195, 8'd203, 8'd235, 8'd239,
    8'd231, 8'd199, 8'd71,  8'd7,   8'd23,  8'd19,  8'd3,   8'd1,   8'd9,   8'd41,  8'd169,
    8'd233, 8'd225, 8'd229, 8'd245, 8'd247, 8'd243, 8'd227, 8'd163,
    8'd131, 8'd139, 8'd137, 8'd129, 8'd128, 8'd132,
    8'd148, 8'd212, 8'd244, 8'd240, 8'd242, 8'd250, 8'd251, 8'd249, 8'd241, 8'd209,
    8'd193, 8'd197, 8'd196, 8'd192, 8'd64,  8'd66,  8'd74,  8'd106, 8'd122, 8'd120, 8'd121,
    8'd125, 8'd253, 8'd252, 8'd248, 8'd232, 8'd224, 8'd226, 8'd98,  8'd96,  8'd32,  8'd33,
    8'd37,  8'd53,  8'd61,  8'd60,  8'd188, 8'd190, 8'd254, 8'd126, 8'd124, 8'd116, 8'd112,
    8'd113, 8'd49,  8'd48,  8'd16,  8'd144, 8'd146, 8'd154, 8'd158, 8'd30,  8'd94,  8'd95
  };

  // One result transaction as the block should deliver it.
  typedef struct packed {
    logic                      enc;
    logic [POS_W-1:0]          pos;
    logic                      err;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic                      wl;
    logic                      wh;
    ev_e                       lev;
    ev_e                       hev;
  } result_t;

  // A row of the opening sequence: the sample, and a hand-written result where one is given.
  typedef struct packed {
    logic              sel;
    logic [CODE_W-1:0] code;
    logic              typed;
    result_t           hand;
  } opening_t;

  // A register setting; bit 0 of writes selects the window, bit 1 the low and bit 2 the
  // high threshold. Values may carry junk above the register width on purpose.
  typedef struct packed {
    logic [2:0]  writes;
    logic [31:0] win;
    logic [31:0] low;
    logic [31:0] high;
  } setting_t;

  localparam result_t NO_HAND = '{1'b0, 7'd0, 1'b0, 8'sd0, 14'sd0, 1'b0, 1'b0, EV_NONE, EV_NONE};

  // The opening sequence starts from reset state (window 26, thresholds 16 and 32), so the
  // first rows can be worked out by hand: the zero position, a step backwards across the
  // wrap on the second encoder, the lowest and highest pin codes that are not in the table,
  // and a step backwards and then forwards across the wrap on the first encoder. The remaining
  // rows are left to the predictor: the largest steps, both directions of the wrap at its
  // exact limits, warnings being set and cleared, and an unknown code on the second encoder.
  opening_t opening_samples [OPENING_ROWS] = '{
    '{1'b0, 8'd127, 1'b1, '{1'b0, 7'd0,   1'b0, 8'sd0,  14'sd0,  1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b1, 8'd95,  1'b1, '{1'b1, 7'd127, 1'b0, -8'sd1, -14'sd1, 1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b1, 8'd0,   1'b1, '{1'b1, 7'd127, 1'b1, 8'sd0,  -14'sd1, 1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b0, 8'd255, 1'b1, '{1'b0, 7'd0,   1'b1, 8'sd0,  14'sd0,  1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b0, 8'd95,  1'b1, '{1'b0, 7'd127, 1'b0, -8'sd1, -14'sd1, 1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b0, 8'd127, 1'b1, '{1'b0, 7'd0,   1'b0, 8'sd1,  14'sd0,  1'b0, 1'b0, EV_NONE, EV_NONE}},
    '{1'b0, 8'd224, 1'b0, NO_HAND},  // position 100, largest forward step
    '{1'b0, 8'd226, 1'b0, NO_HAND},  // position 101
    '{1'b0, 8'd166, 1'b0, NO_HAND},  // 101 to 27 wraps forwards
    '{1'b0, 8'd226, 1'b0, NO_HAND},  // 27 to 101 wraps backwards
    '{1'b0, 8'd167, 1'b0, NO_HAND},  // position 28
    '{1'b0, 8'd95,  1'b0, NO_HAND},  // 28 to 127 does not wrap
    '{1'b0, 8'd127, 1'b0, NO_HAND},
    '{1'b0, 8'd224, 1'b0, NO_HAND},
    '{1'b0, 8'd127, 1'b0, NO_HAND},  // 100 to 0 does not wrap
    '{1'b0, 8'd32,  1'b0, NO_HAND},  // position 104
    '{1'b0, 8'd167, 1'b0, NO_HAND},  // high warning clears
    '{1'b0, 8'd127, 1'b0, NO_HAND},  // low warning clears
    '{1'b1, 8'd63,  1'b0, NO_HAND},
    '{1'b1, 8'd90,  1'b0, NO_HAND},
    '{1'b0, 8'd128, 1'b0, NO_HAND},
    '{1'b0, 8'd1,   1'b0, NO_HAND}
  };

  // Register settings of the random phases, extremes first.
  setting_t fixed_settings [FIXED_SETTINGS] = '{
    '{3'b111, 32'd1,          32'd0,    32'd0},           // shortest window, zero thresholds
    '{3'b111, 32'd64,         32'd8128, 32'd8128},        // longest window, top thresholds
    '{3'b110, 32'd0,          32'd40,   32'd150},         // thresholds only, history kept
    '{3'b111, 32'hFFFF_FF80,  32'd3,    32'hA5A5_FFFF},   // window of zero, high all ones
    '{3'b111, 32'd127,        32'd100,  32'd600},         // window beyond the ring depth
    '{3'b111, 32'd65,         32'd20,   32'd10},          // high below low
    '{3'b111, 32'd26,         32'd16,   32'd32}           // back to the reset values
  };

  logic                      clk;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      encoder_select_i;
  logic [CODE_W-1:0]         raw_code_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      encoder_id_o;
  logic [POS_W-1:0]          position_o;
  logic                      code_error_o;
  logic signed [DELTA_W-1:0] step_delta_o;
  logic signed [SUM_W-1:0]   window_sum_o;
  logic                      warn_low_o;
  logic                      warn_high_o;
  logic [1:0]                low_event_o;
  logic [1:0]                high_event_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // The predictor's copy of the configuration and of the per-encoder state.
  logic [WIN_W-1:0]          win_len;
  logic [THR_W-1:0]          low_thr;
  logic [THR_W-1:0]          high_thr;
  logic [POS_W-1:0]          last_pos   [2];
  logic signed [DELTA_W-1:0] delta_hist [2][HIST];
  logic [IDX_W-1:0]          ring_head  [2];
  logic signed [SUM_W-1:0]   run_sum    [2];
  logic                      low_flag   [2];
  logic                      high_flag  [2];

  // Results still owed by the block, oldest first.
  result_t awaited_results [$];

  int mismatch_count;
  int samples_accepted;
  int unknown_codes;
  int warn_sets;
  int warn_clears;
  int settings_run;

  // Idling controls: whether the sender leaves gaps, and how hard the receiver stalls.
  bit send_gaps;
  int stall_mode;

  absolute_encoder_speed_monitor_top #(
    .HISTORY_DEPTH(HIST)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .encoder_select_i(encoder_select_i),
    .raw_code_i      (raw_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .encoder_id_o    (encoder_id_o),
    .position_o      (position_o),
    .code_error_o    (code_error_o),
    .step_delta_o    (step_delta_o),
    .window_sum_o    (window_sum_o),
    .warn_low_o      (warn_low_o),
    .warn_high_o     (warn_high_o),
    .low_event_o     (low_event_o),
    .high_event_o    (high_event_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A generous ceiling: far above the slowest correct run with every gap and stall long.
  initial begin
    #10_000_000;
    $display("FAIL absolute_encoder_speed_monitor_top");
    $finish;
  end

  function automatic void compare_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endfunction

  function automatic ev_e warn_change(input logic was, input logic now);
    if (!was && now) begin
      return EV_SET;
    end else if (was && !now) begin
      return EV_CLEAR;
    end
    return EV_NONE;
  endfunction

  function automatic void clear_history();
    for (int e = 0; e < 2; e++) begin
      ring_head[e] = '0;
      run_sum[e]   = '0;
      for (int i = 0; i < HIST; i++) begin
        delta_hist[e][i] = '0;
      end
    end
  endfunction

  // Decodes one sample, advances that encoder's ring and window sum, and returns the
  // result transaction that the block owes for it.
  function automatic result_t predict_speed_result(input logic sel,
                                                   input logic [CODE_W-1:0] code);
    result_t          r;
    int               prev;
    int               cur;
    int               step;
    int               span;
    int               total;
    int               mag;
    bit               hit;
    logic [IDX_W-1:0] back;
    prev = int'(last_pos[sel]);
    cur  = prev;
    hit  = 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (!hit && PIN_CODES[i] == code) begin
        cur = i;
        hit = 1'b1;
      end
    end
    // The shortest way round near the wrap: low new with high old means forwards.
    if (cur < 28 && prev > 100) begin
      step = cur + 128 - prev;
    end else if (cur > 100 && prev < 28) begin
      step = cur - prev - 128;
    end else begin
      step = cur - prev;
    end
    span = (win_len < 1) ? 1 : ((int'(win_len) > SPAN_CAP) ? SPAN_CAP : int'(win_len));
    // The delta leaving the window is read before the new one is written, which matters
    // when the window spans the whole ring.
    back  = ring_head[sel] - IDX_W'(span);
    total = int'(run_sum[sel]) + step - int'(delta_hist[sel][back]);
    delta_hist[sel][ring_head[sel]] = DELTA_W'(step);
    ring_head[sel] = ring_head[sel] + 1'b1;
    run_sum[sel]   = SUM_W'(total);
    last_pos[sel]  = POS_W'(cur);
    mag = (total < 0) ? -total : total;
    r.enc   = sel;
    r.pos   = POS_W'(cur);
    r.err   = !hit;
    r.delta = DELTA_W'(step);
    r.sum   = SUM_W'(total);
    r.wl    = mag > int'(low_thr);
    r.wh    = mag > int'(high_thr);
    r.lev   = warn_change(low_flag[sel], r.wl);
    r.hev   = warn_change(high_flag[sel], r.wh);
    low_flag[sel]  = r.wl;
    high_flag[sel] = r.wh;
    warn_sets   += int'(r.lev == EV_SET) + int'(r.hev == EV_SET);
    warn_clears += int'(r.lev == EV_CLEAR) + int'(r.hev == EV_CLEAR);
    unknown_codes += int'(r.err);
    return r;
  endfunction

  // Offers one sample and returns in the time step of the edge that accepted it. Valid
  // stays high into the next sample when no gap is drawn, so it is never lowered and
  // raised in the same step.
  task automatic send_sample(input logic sel, input logic [CODE_W-1:0] code,
                             input logic typed, input result_t hand);
    int      gap;
    int      roll;
    result_t r;
    gap  = 0;
    roll = $urandom_range(0, 99);
    if (send_gaps) begin
      if (roll >= 95) begin
        gap = $urandom_range(8, 40);
      end else if (roll >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i       <= 1'b1;
    encoder_select_i <= sel;
    raw_code_i       <= code;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    r = predict_speed_result(sel, code);
    awaited_results.push_back(typed ? hand : r);
    samples_accepted++;
  endtask

  // Stops sending and waits until every owed result has arrived and the block has settled.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register access: setup phase, access phase, then an idle phase so that the next
  // access starts in a fresh time step.
  task automatic apb_access(input logic wr, input logic [1:0] index,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({index, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] index);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, index, '0, rd);
    case (index)
      REG_WINDOW: compare_field("window_length readback", 32'(win_len), rd);
      REG_LOW:    compare_field("low_threshold readback", 32'(low_thr), rd);
      REG_HIGH:   compare_field("high_threshold readback", 32'(high_thr), rd);
      default:    ;
    endcase
  endtask

  task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, index, value, rd);
    case (index)
      REG_WINDOW: begin
        // A new window empties both rings and sums; positions and warnings survive.
        win_len = value[WIN_W-1:0];
        clear_history();
      end
      REG_LOW:  low_thr  = value[THR_W-1:0];
      REG_HIGH: high_thr = value[THR_W-1:0];
      default:  ;
    endcase
    if (index != REG_SPARE) begin
      check_register(index);
    end
  endtask

  // The receiver: stalls in runs of random length, mostly short with the odd long one.
  // In mode 0 it never stalls, which gives stretches at full rate.
  initial begin : stall_driver
    int hold;
    int pct;
    bit level;
    hold = 0;
    level = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_mode == 0) begin
        level = 1'b0;
        hold  = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        pct   = (stall_mode == 1) ? 25 : 50;
        level = ($urandom_range(0, 99) < pct);
        hold  = ($urandom_range(0, 99) < 4) ? $urandom_range(12, 40) : $urandom_range(0, 3);
      end
      out_stall_i <= level;
    end
  end

  // Every accepted result transaction is matched against the oldest owed one.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $error("result with no sample waiting: encoder %0d, position %0d",
               encoder_id_o, position_o);
      end else begin
        want = awaited_results.pop_front();
        compare_field("encoder_id", 32'(want.enc), 32'(encoder_id_o));
        compare_field("position", 32'(want.pos), 32'(position_o));
        compare_field("code_error", 32'(want.err), 32'(code_error_o));
        compare_field("step_delta", 32'(want.delta), 32'(step_delta_o));
        compare_field("window_sum", 32'(want.sum), 32'(window_sum_o));
        compare_field("warn_low", 32'(want.wl), 32'(warn_low_o));
        compare_field("warn_high", 32'(want.wh), 32'(warn_high_o));
        compare_field("low_event", 32'(want.lev), 32'(low_event_o));
        compare_field("high_event", 32'(want.hev), 32'(high_event_o));
      end
    end
  end

  initial begin : stimulus
    setting_t          s;
    int                speed [2];
    int                jitter;
    int                roll;
    int                pos;
    logic              sel;
    logic [CODE_W-1:0] code;

    // Every input is known from the very first step.
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    encoder_select_i = 1'b0;
    raw_code_i       = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_gaps        = 1'b1;
    stall_mode       = 1;
    mismatch_count   = 0;
    samples_accepted = 0;
    unknown_codes    = 0;
    warn_sets        = 0;
    warn_clears      = 0;
    settings_run     = 1;

    // The predictor starts from the documented reset state.
    win_len  = 7'd26;
    low_thr  = 13'd16;
    high_thr = 13'd32;
    for (int e = 0; e < 2; e++) begin
      last_pos[e]  = '0;
      low_flag[e]  = 1'b0;
      high_flag[e] = 1'b0;
    end
    clear_history();

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // The registers must read back their reset values before anything is written.
    check_register(REG_WINDOW);
    check_register(REG_LOW);
    check_register(REG_HIGH);

    foreach (opening_samples[i]) begin
      send_sample(opening_samples[i].sel, opening_samples[i].code,
                  opening_samples[i].typed, opening_samples[i].hand);
    end
    drain_results();

    // Random phases. Each begins from an idle block with a new register setting and a
    // new mix of sender gaps and receiver stalls. Most samples follow a plausible motion
    // of each encoder, so that window sums build up and warnings are set and cleared; a
    // share jump to any position, and the rest are raw noise, unknown codes among them.
    for (int ph = 0; ph < FIXED_SETTINGS + RANDOM_SETTINGS; ph++) begin
      if (ph < FIXED_SETTINGS) begin
        s = fixed_settings[ph];
      end else begin
        s.writes = 3'b111;
        s.win    = $urandom_range(0, 127);
        s.low    = $urandom_range(0, 300);
        s.high   = $urandom_range(0, 600);
      end
      drain_results();
      if (s.writes[0]) write_register(REG_WINDOW, s.win);
      if (s.writes[1]) write_register(REG_LOW, s.low);
      if (s.writes[2]) write_register(REG_HIGH, s.high);
      // Once, a write to the unused address, which must change nothing.
      if (ph == 2) write_register(REG_SPARE, '1);
      settings_run++;
      send_gaps  = (ph % 3 != 1);
      stall_mode = ph % 3;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          for (int e = 0; e < 2; e++) begin
            if ($urandom_range(0, 99) < 20) begin
              speed[e] = $urandom_range(10, 40);
              if ($urandom_range(0, 1)) speed[e] = -speed[e];
            end else begin
              speed[e] = $urandom_range(0, 8);
              speed[e] = speed[e] - 4;
            end
          end
        end
        sel  = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          jitter = $urandom_range(0, 2);
          pos    = int'(last_pos[sel]) + speed[sel] + jitter - 1;
          code   = PIN_CODES[pos & 127];
        end else if (roll < 87) begin
          code = PIN_CODES[$urandom_range(0, 127)];
        end else begin
          code = CODE_W'($urandom_range(0, 255));
        end
        send_sample(sel, code, 1'b0, NO_HAND);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d samples under %0d register settings, %0d of them unknown codes.",
             samples_accepted, settings_run, unknown_codes);
    $display("Warnings were set %0d times and cleared %0d times; %0d mismatches.",
             warn_sets, warn_clears, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS absolute_encoder_speed_monitor_top");
    end else begin
      $display("FAIL absolute_encoder_speed_monitor_top");
    end
    $finish;
  end

endmodule
